### hw/rtl/ncv_pkg.sv
package ncv_pkg;

  // Default geometry
  localparam int LineBytesDef  = 128;
  localparam int NonceBytesDef = 64;

  // Try limit after reset and saturation value of the failed-try counter
  localparam logic [3:0] MAX_TRIES_RST = 4'd3;
  localparam logic [3:0] TRIES_SAT     = 4'd15;

  // Characters
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_LOW  = 8'h20;  // space
  localparam logic [7:0] CHAR_HIGH = 8'h7E;  // tilde
  localparam logic [7:0] CHAR_FOUR = 8'h34;
  localparam logic [7:0] CHAR_TWO  = 8'h32;

  // Prefix lengths and nonce offsets within a line
  localparam int VerifyWordLen = 6;
  localparam int StoreWordLen  = 5;
  localparam int VerifyOffset  = 7;
  localparam int StoreOffset   = 6;

  // Result status codes
  localparam logic [2:0] ST_VERIFIED    = 3'd0;
  localparam logic [2:0] ST_WRITTEN     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN     = 3'd2;
  localparam logic [2:0] ST_VERIFY_FAIL = 3'd3;
  localparam logic [2:0] ST_NOT_VERIF   = 3'd4;
  localparam logic [2:0] ST_BAD_NONCE   = 3'd5;
  localparam logic [2:0] ST_TRIES_EXC   = 3'd6;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_byte;   // input transfer this cycle
    logic decide;      // classify the finished line
    logic issue_cmp;   // read one nonce/line pair for compare
    logic issue_copy;  // read one line byte for copy into the nonce
    logic resolve;     // settle a verify command
    logic store_done;  // report a completed nonce write
    logic finish;      // load the result register, clear the line
  } ncv_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic line_end;    // offered byte ends the line
    logic go_cmp;      // line needs the compare sweep
    logic go_copy;     // line needs the copy sweep
    logic go_resolve;  // verify line too short, settle as mismatch
    logic idx_last;    // sweep index at the last nonce byte
  } ncv_stat_t;

  function automatic logic [7:0] verify_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h76;  // v
      3'd1:    c = 8'h65;  // e
      3'd2:    c = 8'h72;  // r
      3'd3:    c = 8'h69;  // i
      3'd4:    c = 8'h66;  // f
      3'd5:    c = 8'h79;  // y
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] store_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h73;  // s
      3'd1:    c = 8'h74;  // t
      3'd2:    c = 8'h6F;  // o
      3'd3:    c = 8'h72;  // r
      3'd4:    c = 8'h65;  // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/ncv_datapath.sv
module ncv_datapath #(
  parameter int LINE_BYTES  = ncv_pkg::LineBytesDef,
  parameter int NONCE_BYTES = ncv_pkg::NonceBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic [7:0]        rx_byte_i,
  input  ncv_pkg::ncv_cmd_t cmd_i,
  output ncv_pkg::ncv_stat_t stat_o,
  output logic [2:0]        status_o,
  output logic              led_lit_o
);

  localparam int LEN_W  = $clog2(LINE_BYTES + 1);
  localparam int LIDX_W = $clog2(LINE_BYTES);
  localparam int NIDX_W = (NONCE_BYTES > 1) ? $clog2(NONCE_BYTES) : 1;
  localparam int SUM_W  = LEN_W + 1;

  localparam logic [SUM_W-1:0] VERIFY_LEN = SUM_W'(NONCE_BYTES + ncv_pkg::VerifyOffset);
  localparam logic [SUM_W-1:0] STORE_LEN  = SUM_W'(NONCE_BYTES + ncv_pkg::StoreOffset);
  localparam logic [LEN_W-1:0] LEN_VWORD  = LEN_W'(ncv_pkg::VerifyWordLen);
  localparam logic [LEN_W-1:0] LEN_SWORD  = LEN_W'(ncv_pkg::StoreWordLen);
  localparam logic [LEN_W-1:0] LEN_FULL   = LEN_W'(LINE_BYTES - 1);
  localparam logic [NIDX_W-1:0] IDX_LAST  = NIDX_W'(NONCE_BYTES - 1);
  localparam logic [SUM_W-1:0] OFS_VERIFY = SUM_W'(ncv_pkg::VerifyOffset);
  localparam logic [SUM_W-1:0] OFS_STORE  = SUM_W'(ncv_pkg::StoreOffset);

  // Storage
  logic [7:0] line_mem  [LINE_BYTES];
  logic [7:0] nonce_mem [NONCE_BYTES];
  logic [NONCE_BYTES-1:0] nonce_vld_q, nonce_vld_d;

  // Control and line state
  logic [LEN_W-1:0]  len_q, len_d;
  logic              pfx_v_q, pfx_v_d;
  logic              pfx_s_q, pfx_s_d;
  logic              verified_q, verified_d;
  logic [3:0]        failed_q, failed_d;
  logic [3:0]        max_q, max_d;
  logic              mismatch_q, mismatch_d;
  logic [NIDX_W-1:0] idx_q, idx_d;
  logic              cmp_vld_q, copy_vld_q;
  logic [NIDX_W-1:0] copy_widx_q;
  logic [2:0]        code_q, code_d;
  logic [2:0]        status_q;
  logic              led_q;

  // Read data
  logic [7:0] line_rdata_q;
  logic [7:0] nonce_rdata_q;
  logic       nonce_rvld_q;
  logic       nonce_rodd_q;
  logic [7:0] nonce_val;

  logic             printable;
  logic             is_eol;
  logic             append;
  logic [SUM_W-1:0] len_x;
  logic             has_vpfx, has_spfx, tries_hit;
  logic             line_rd_en;
  logic [SUM_W-1:0] line_raddr_sum;
  logic [LIDX_W-1:0] line_raddr;

  // Classify the offered byte
  assign printable = (rx_byte_i >= ncv_pkg::CHAR_LOW) && (rx_byte_i <= ncv_pkg::CHAR_HIGH);
  assign is_eol    = (rx_byte_i == ncv_pkg::CHAR_CR) || (rx_byte_i == ncv_pkg::CHAR_LF);
  assign append    = cmd_i.take_byte && printable;

  // Line state checks
  assign len_x     = {1'b0, len_q};
  assign has_vpfx  = (len_q >= LEN_VWORD) && pfx_v_q;
  assign has_spfx  = (len_q >= LEN_SWORD) && pfx_s_q;
  assign tries_hit = failed_q >= max_q;

  // Status toward the controller
  always_comb begin
    stat_o            = '0;
    stat_o.line_end   = is_eol || (printable && (len_q == LEN_FULL));
    stat_o.idx_last   = idx_q == IDX_LAST;
    if (!tries_hit) begin
      if (has_vpfx && !verified_q) begin
        stat_o.go_cmp     = len_x >= VERIFY_LEN;
        stat_o.go_resolve = len_x < VERIFY_LEN;
      end else if (has_spfx && verified_q) begin
        stat_o.go_copy    = len_x >= STORE_LEN;
      end
    end
  end

  // Next-state logic
  always_comb begin
    len_d       = len_q;
    pfx_v_d     = pfx_v_q;
    pfx_s_d     = pfx_s_q;
    verified_d  = verified_q;
    failed_d    = failed_q;
    max_d       = max_q;
    mismatch_d  = mismatch_q;
    idx_d       = idx_q;
    code_d      = code_q;
    nonce_vld_d = nonce_vld_q;

    if (cfg_we_i) begin
      max_d = cfg_wdata_i;
    end

    // Append and track the command prefixes
    if (append) begin
      len_d = len_q + LEN_W'(1);
      if (len_q < LEN_VWORD) begin
        pfx_v_d = ((len_q == '0) || pfx_v_q) &&
                  (rx_byte_i == ncv_pkg::verify_char(len_q[2:0]));
      end
      if (len_q < LEN_SWORD) begin
        pfx_s_d = ((len_q == '0) || pfx_s_q) &&
                  (rx_byte_i == ncv_pkg::store_char(len_q[2:0]));
      end
    end

    // Classify the line; short verify lines settle as a mismatch
    if (cmd_i.decide) begin
      idx_d      = '0;
      mismatch_d = 1'b0;
      if (tries_hit) begin
        code_d = ncv_pkg::ST_TRIES_EXC;
      end else if (has_vpfx && !verified_q) begin
        mismatch_d = len_x < VERIFY_LEN;
      end else if (has_spfx) begin
        if (!verified_q) begin
          code_d = ncv_pkg::ST_NOT_VERIF;
        end else begin
          code_d = ncv_pkg::ST_BAD_NONCE;
        end
      end else begin
        code_d = ncv_pkg::ST_UNKNOWN;
      end
    end

    // Advance the sweep index
    if (cmd_i.issue_cmp || cmd_i.issue_copy) begin
      idx_d = idx_q + NIDX_W'(1);
    end

    // Compare the pair read in the previous cycle
    if (cmp_vld_q && (line_rdata_q != nonce_val)) begin
      mismatch_d = 1'b1;
    end

    // Mark copied nonce bytes as written
    if (copy_vld_q) begin
      nonce_vld_d[copy_widx_q] = 1'b1;
    end

    if (cmd_i.resolve) begin
      if (!mismatch_q) begin
        verified_d = 1'b1;
        code_d     = ncv_pkg::ST_VERIFIED;
      end else begin
        if (failed_q != ncv_pkg::TRIES_SAT) begin
          failed_d = failed_q + 4'd1;
        end
        code_d = ncv_pkg::ST_VERIFY_FAIL;
      end
    end

    if (cmd_i.store_done) begin
      code_d = ncv_pkg::ST_WRITTEN;
    end

    if (cmd_i.finish) begin
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pfx_v_q     <= 1'b0;
      pfx_s_q     <= 1'b0;
      verified_q  <= 1'b0;
      failed_q    <= '0;
      max_q       <= ncv_pkg::MAX_TRIES_RST;
      mismatch_q  <= 1'b0;
      idx_q       <= '0;
      code_q      <= ncv_pkg::ST_UNKNOWN;
      nonce_vld_q <= '0;
      cmp_vld_q   <= 1'b0;
      copy_vld_q  <= 1'b0;
    end else begin
      len_q       <= len_d;
      pfx_v_q     <= pfx_v_d;
      pfx_s_q     <= pfx_s_d;
      verified_q  <= verified_d;
      failed_q    <= failed_d;
      max_q       <= max_d;
      mismatch_q  <= mismatch_d;
      idx_q       <= idx_d;
      code_q      <= code_d;
      nonce_vld_q <= nonce_vld_d;
      cmp_vld_q   <= cmd_i.issue_cmp;
      copy_vld_q  <= cmd_i.issue_copy;
    end
  end

  // Result payload and copy write index
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= code_q;
      led_q    <= verified_q;
    end
    copy_widx_q <= idx_q;
  end

  // Line store: write on append, read for compare or copy
  assign line_rd_en     = cmd_i.issue_cmp || cmd_i.issue_copy;
  assign line_raddr_sum = SUM_W'(idx_q) + (cmd_i.issue_cmp ? OFS_VERIFY : OFS_STORE);
  assign line_raddr     = line_raddr_sum[LIDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (append) begin
      line_mem[len_q[LIDX_W-1:0]] <= rx_byte_i;
    end
    if (line_rd_en) begin
      line_rdata_q <= line_mem[line_raddr];
    end
  end

  // Nonce store: unwritten entries read as the 4/2 pattern
  always_ff @(posedge clk_i) begin
    if (copy_vld_q) begin
      nonce_mem[copy_widx_q] <= line_rdata_q;
    end
    if (cmd_i.issue_cmp) begin
      nonce_rdata_q <= nonce_mem[idx_q];
      nonce_rvld_q  <= nonce_vld_q[idx_q];
      nonce_rodd_q  <= idx_q[0];
    end
  end

  assign nonce_val = nonce_rvld_q ? nonce_rdata_q :
                     (nonce_rodd_q ? ncv_pkg::CHAR_TWO : ncv_pkg::CHAR_FOUR);

  assign status_o  = status_q;
  assign led_lit_o = led_q;

endmodule

### hw/rtl/ncv_ctrl.sv
module ncv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ncv_pkg::ncv_stat_t stat_i,
  output ncv_pkg::ncv_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DECIDE     = 3'd1;
  localparam logic [2:0] S_CMP        = 3'd2;
  localparam logic [2:0] S_CMP_DRAIN  = 3'd3;
  localparam logic [2:0] S_RESOLVE    = 3'd4;
  localparam logic [2:0] S_COPY       = 3'd5;
  localparam logic [2:0] S_COPY_DRAIN = 3'd6;
  localparam logic [2:0] S_FINISH     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       slot_free;

  assign in_ready_o = state_q == S_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Sequence one line end through decide, sweep and result
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.take_byte = in_fire;
    case (state_q)
      S_IDLE: begin
        if (in_fire && stat_i.line_end) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.go_cmp) begin
          state_d = S_CMP;
        end else if (stat_i.go_copy) begin
          state_d = S_COPY;
        end else if (stat_i.go_resolve) begin
          state_d = S_RESOLVE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_CMP: begin
        cmd_o.issue_cmp = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_CMP_DRAIN;
        end
      end
      S_CMP_DRAIN: begin
        state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        state_d       = S_FINISH;
      end
      S_COPY: begin
        cmd_o.issue_copy = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_COPY_DRAIN;
        end
      end
      S_COPY_DRAIN: begin
        cmd_o.store_done = 1'b1;
        state_d          = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result valid until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/nonce_command_verifier.sv
// Line-oriented command checker. Bytes enter one per transfer; printable bytes
// (space to tilde) collect in a line store, other bytes are dropped, and CR, LF
// or a full store ends the line with exactly one result (status, LED flag).
// A line end runs decide; then the compare sweep, drain and resolve for a full
// verify line, resolve alone for a short verify line, the copy sweep and drain
// for a nonce write, nothing for refused, unknown or rejected lines; and last
// finish. The sweeps walk the single read port of the line store one byte a
// cycle; no byte is taken until the line end is done. The result sits in an
// output register; a line end waits there only while a previous result has
// not been taken. The user must write max_tries through cfg_we_i/cfg_wdata_i
// only while the block is idle; the block itself does not enforce it.
module nonce_command_verifier #(
  parameter int LINE_BYTES  = ncv_pkg::LineBytesDef,
  parameter int NONCE_BYTES = ncv_pkg::NonceBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic       led_lit_o
);

  ncv_pkg::ncv_cmd_t  cmd;
  ncv_pkg::ncv_stat_t stat;

  ncv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ncv_datapath #(
    .LINE_BYTES  (LINE_BYTES),
    .NONCE_BYTES (NONCE_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_byte_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .status_o    (status_o),
    .led_lit_o   (led_lit_o)
  );

endmodule
